// File: rtl/csdi_pkg.sv
package csdi_pkg;

	localparam int DEF_MAX_KNOTS = 256;
	localparam int QW = 48;
	localparam int RW = 160;

	localparam logic signed [QW-1:0] Q_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [QW-1:0] Q_MIN = 48'sh8000_0000_0000;
	localparam logic signed [QW-1:0] K_HALF = 48'sd32768;
	localparam logic signed [QW-1:0] K_THIRD = 48'sd21845;
	localparam logic signed [QW-1:0] K_QUARTER = 48'sd16384;
	localparam logic signed [QW-1:0] K_SIXTH = 48'sd10923;

	typedef enum logic [1:0] {UOP_ADD, UOP_SUB, UOP_MUL} uop_op_t;

	typedef enum logic [4:0] {
		OPD_ZERO, OPD_T, OPD_U, OPD_D, OPD_QA, OPD_QB, OPD_QAB,
		OPD_Y, OPD_C1, OPD_C2, OPD_C3, OPD_YP, OPD_C2P, OPD_DX,
		OPD_HALF, OPD_THIRD, OPD_QUARTER, OPD_SIXTH
	} opnd_t;

	typedef enum logic [2:0] {DST_T, DST_U, DST_QA, DST_QB, DST_QAB} dst_t;

	typedef struct packed {
		uop_op_t op;
		opnd_t   a;
		opnd_t   b;
		dst_t    dst;
		logic    last;
	} uop_t;

	typedef logic [5:0] upc_t;

	localparam upc_t PC_PA = 6'd0;
	localparam upc_t PC_PB = 6'd10;
	localparam upc_t PC_IV = 6'd20;
	localparam upc_t PC_FWD = 6'd29;
	localparam upc_t PC_REV = 6'd31;
	localparam upc_t PC_ZERO = 6'd33;

	typedef struct packed {
		logic cap;
		logic ram_we;
		logic ram_rd;
		logic v_hi;
		logic d_row;
		logic d_dd;
		logic row_lt;
		logic qab_clr;
		logic alu_go;
		logic mul_go;
		logic out_load;
		uop_t uop;
	} cmd_t;

	typedef struct packed {
		logic lim_eq;
		logic swap;
		logic dd_neg;
		logic dd_pos;
		logic d_neg;
		logic mul_done;
	} sts_t;

	function automatic uop_t mk(uop_op_t op, opnd_t a, opnd_t b, dst_t dst, logic last);
		uop_t u;
		u.op = op;
		u.a = a;
		u.b = b;
		u.dst = dst;
		u.last = last;
		return u;
	endfunction

	// partial integral of the current row: d*(y + d*(c1/2 + d*(c2/3 + d*c3/4)))
	function automatic uop_t ucode(upc_t pc);
		uop_t u;
		case (pc)
			6'd0, 6'd10: u = mk(UOP_MUL, OPD_C3, OPD_QUARTER, DST_T, 1'b0);
			6'd1, 6'd11: u = mk(UOP_MUL, OPD_T, OPD_D, DST_T, 1'b0);
			6'd2, 6'd12: u = mk(UOP_MUL, OPD_C2, OPD_THIRD, DST_U, 1'b0);
			6'd3, 6'd13: u = mk(UOP_ADD, OPD_T, OPD_U, DST_T, 1'b0);
			6'd4, 6'd14: u = mk(UOP_MUL, OPD_T, OPD_D, DST_T, 1'b0);
			6'd5, 6'd15: u = mk(UOP_MUL, OPD_C1, OPD_HALF, DST_U, 1'b0);
			6'd6, 6'd16: u = mk(UOP_ADD, OPD_T, OPD_U, DST_T, 1'b0);
			6'd7, 6'd17: u = mk(UOP_MUL, OPD_T, OPD_D, DST_T, 1'b0);
			6'd8, 6'd18: u = mk(UOP_ADD, OPD_T, OPD_Y, DST_T, 1'b0);
			6'd9: u = mk(UOP_MUL, OPD_T, OPD_D, DST_QA, 1'b1);
			6'd19: u = mk(UOP_MUL, OPD_T, OPD_D, DST_QB, 1'b1);
			// one whole interval between previous and current row
			6'd20: u = mk(UOP_ADD, OPD_C2, OPD_C2P, DST_U, 1'b0);
			6'd21: u = mk(UOP_MUL, OPD_U, OPD_DX, DST_U, 1'b0);
			6'd22: u = mk(UOP_MUL, OPD_U, OPD_DX, DST_U, 1'b0);
			6'd23: u = mk(UOP_MUL, OPD_U, OPD_SIXTH, DST_U, 1'b0);
			6'd24: u = mk(UOP_ADD, OPD_Y, OPD_YP, DST_T, 1'b0);
			6'd25: u = mk(UOP_SUB, OPD_T, OPD_U, DST_T, 1'b0);
			6'd26: u = mk(UOP_MUL, OPD_HALF, OPD_DX, DST_U, 1'b0);
			6'd27: u = mk(UOP_MUL, OPD_U, OPD_T, DST_U, 1'b0);
			6'd28: u = mk(UOP_ADD, OPD_QAB, OPD_U, DST_QAB, 1'b1);
			6'd29: u = mk(UOP_SUB, OPD_QB, OPD_QA, DST_T, 1'b0);
			6'd30: u = mk(UOP_ADD, OPD_T, OPD_QAB, DST_T, 1'b1);
			6'd31: u = mk(UOP_SUB, OPD_QA, OPD_QB, DST_T, 1'b0);
			6'd32: u = mk(UOP_SUB, OPD_T, OPD_QAB, DST_T, 1'b1);
			default: u = mk(UOP_ADD, OPD_ZERO, OPD_ZERO, DST_T, 1'b1);
		endcase
		return u;
	endfunction

	function automatic logic signed [QW-1:0] sat_add(logic signed [QW-1:0] a,
			logic signed [QW-1:0] b, logic sub);
		logic signed [QW+1:0] ea;
		logic signed [QW+1:0] eb;
		logic signed [QW+1:0] s;
		ea = (QW+2)'(a);
		eb = (QW+2)'(b);
		s = sub ? ea - eb : ea + eb;
		if (s > (QW+2)'(Q_MAX))
			return Q_MAX;
		if (s < (QW+2)'(Q_MIN))
			return Q_MIN;
		return s[QW-1:0];
	endfunction

endpackage

// File: rtl/csdi_ram.sv
module csdi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// File: rtl/csdi_mul.sv
module csdi_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [csdi_pkg::QW-1:0]    a,
	input  logic signed [csdi_pkg::QW-1:0]    b,
	output logic                              done,
	output logic signed [csdi_pkg::QW-1:0]    res
);
	import csdi_pkg::*;

	logic            busy_q;
	logic [2:0]      cnt_q;
	logic [QW-1:0]   ma_q;
	logic [QW-1:0]   mb_q;
	logic            neg_q;
	logic [QW-1:0]   pp_q;
	logic [1:0]      sh_q;
	logic [2*QW-1:0] acc_q;
	logic            done_q;
	logic signed [QW-1:0] res_q;

	logic [23:0]     ha;
	logic [23:0]     hb;
	logic [2*QW-1:0] pp_sh;
	logic [QW:0]     rnd;
	logic            big;
	logic signed [QW-1:0] fin;

	assign ha = cnt_q[1] ? ma_q[47:24] : ma_q[23:0];
	assign hb = cnt_q[0] ? mb_q[47:24] : mb_q[23:0];

	always_comb begin
		case (sh_q)
			2'd0: pp_sh = {48'b0, pp_q};
			2'd1: pp_sh = {24'b0, pp_q, 24'b0};
			default: pp_sh = {pp_q, 48'b0};
		endcase
	end

	// products of 2^64 or more saturate, else round half away from zero
	assign big = |acc_q[2*QW-1:64];
	assign rnd = {1'b0, acc_q[63:16]} + (QW+1)'(acc_q[15]);

	always_comb begin
		if (big)
			fin = neg_q ? Q_MIN : Q_MAX;
		else if (neg_q)
			fin = (rnd >= (QW+1)'(49'h0_8000_0000_0000)) ? Q_MIN : -$signed(rnd[QW-1:0]);
		else
			fin = (rnd > (QW+1)'(Q_MAX)) ? Q_MAX : $signed(rnd[QW-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q <= a[QW-1] ? QW'(-a) : QW'(a);
			mb_q <= b[QW-1] ? QW'(-b) : QW'(b);
			neg_q <= a[QW-1] ^ b[QW-1];
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q <= 3'd3) begin
				pp_q <= QW'(ha * hb);
				sh_q <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
			end
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4)
				acc_q <= acc_q + pp_sh;
			if (cnt_q == 3'd5)
				res_q <= fin;
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// File: rtl/csdi_dp.sv
module csdi_dp #(
	parameter int MAX_KNOTS = csdi_pkg::DEF_MAX_KNOTS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  csdi_pkg::cmd_t               cmd,
	input  logic [$clog2(MAX_KNOTS)-1:0] ram_addr,
	input  logic [7:0]                   knot_index,
	input  logic signed [31:0]           knot_abscissa,
	input  logic signed [31:0]           knot_ordinate,
	input  logic signed [31:0]           coef_linear,
	input  logic signed [31:0]           coef_quadratic,
	input  logic signed [31:0]           coef_cubic,
	input  logic signed [31:0]           lower_limit,
	input  logic signed [31:0]           upper_limit,
	output csdi_pkg::sts_t               sts,
	output logic signed [csdi_pkg::QW-1:0] integral
);
	import csdi_pkg::*;

	localparam int IW = $clog2(MAX_KNOTS);

	logic [RW-1:0] rdata;
	logic signed [31:0] lo_q, hi_q;
	logic swap_q;
	logic signed [31:0] cx_q, cy_q, c1_q, c2_q, c3_q, px_q, py_q, pc2_q;
	logic signed [QW-1:0] d_q, t_q, u_q, qa_q, qb_q, qab_q, res_q;

	logic signed [31:0] v;
	logic signed [32:0] dd;
	logic signed [32:0] dx;
	logic signed [QW-1:0] opa, opb, sum, wval, mres;
	logic mdone;

	csdi_ram #(.WIDTH(RW), .DEPTH(MAX_KNOTS)) u_ram (
		.clk(clk),
		.we(cmd.ram_we),
		.waddr(IW'(knot_index)),
		.wdata({coef_cubic, coef_quadratic, coef_linear, knot_ordinate, knot_abscissa}),
		.re(cmd.ram_rd),
		.raddr(ram_addr),
		.rdata(rdata)
	);

	assign v = cmd.v_hi ? hi_q : lo_q;
	assign dd = 33'(v) - 33'($signed(rdata[31:0]));
	assign dx = 33'(cx_q) - 33'(px_q);

	function automatic logic signed [QW-1:0] pick(opnd_t s);
		case (s)
			OPD_T: return t_q;
			OPD_U: return u_q;
			OPD_D: return d_q;
			OPD_QA: return qa_q;
			OPD_QB: return qb_q;
			OPD_QAB: return qab_q;
			OPD_Y: return QW'(cy_q);
			OPD_C1: return QW'(c1_q);
			OPD_C2: return QW'(c2_q);
			OPD_C3: return QW'(c3_q);
			OPD_YP: return QW'(py_q);
			OPD_C2P: return QW'(pc2_q);
			OPD_DX: return QW'(dx);
			OPD_HALF: return K_HALF;
			OPD_THIRD: return K_THIRD;
			OPD_QUARTER: return K_QUARTER;
			OPD_SIXTH: return K_SIXTH;
			default: return '0;
		endcase
	endfunction

	always_comb begin
		opa = pick(cmd.uop.a);
		opb = pick(cmd.uop.b);
	end

	assign sum = sat_add(opa, opb, cmd.uop.op == UOP_SUB);

	csdi_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.mul_go),
		.a(opa),
		.b(opb),
		.done(mdone),
		.res(mres)
	);

	assign wval = mdone ? mres : sum;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			lo_q <= (lower_limit < upper_limit) ? lower_limit : upper_limit;
			hi_q <= (lower_limit < upper_limit) ? upper_limit : lower_limit;
			swap_q <= !(lower_limit < upper_limit);
		end
		if (cmd.d_row)
			d_q <= QW'(dd);
		else if (cmd.d_dd)
			d_q <= QW'(dd);
		if (cmd.row_lt) begin
			px_q <= cx_q;
			py_q <= cy_q;
			pc2_q <= c2_q;
			cx_q <= rdata[31:0];
			cy_q <= rdata[63:32];
			c1_q <= rdata[95:64];
			c2_q <= rdata[127:96];
			c3_q <= rdata[159:128];
		end
		if (cmd.qab_clr)
			qab_q <= '0;
		if (cmd.alu_go || mdone) begin
			case (cmd.uop.dst)
				DST_T: t_q <= wval;
				DST_U: u_q <= wval;
				DST_QA: qa_q <= wval;
				DST_QB: qb_q <= wval;
				DST_QAB: qab_q <= wval;
				default: t_q <= wval;
			endcase
		end
		if (cmd.out_load)
			res_q <= t_q;
	end

	assign sts.lim_eq = (lo_q == hi_q);
	assign sts.swap = swap_q;
	assign sts.dd_neg = dd[32];
	assign sts.dd_pos = !dd[32] && (dd != '0);
	assign sts.d_neg = d_q[QW-1];
	assign sts.mul_done = mdone;
	assign integral = res_q;

endmodule

// File: rtl/csdi_ctrl.sv
module csdi_ctrl #(
	parameter int MAX_KNOTS = csdi_pkg::DEF_MAX_KNOTS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic                         operation,
	input  logic [7:0]                   knot_index,
	input  logic                         cfg_wr_en,
	input  logic [8:0]                   cfg_wr_data,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [1:0]                   flags,
	input  csdi_pkg::sts_t               sts,
	output csdi_pkg::cmd_t               cmd,
	output logic [$clog2(MAX_KNOTS)-1:0] ram_addr
);
	import csdi_pkg::*;

	localparam int IW = $clog2(MAX_KNOTS);

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHK, ST_L_RD0, ST_L_D0, ST_L_RD, ST_L_EV, ST_L_FIN,
		ST_R_RD, ST_R_LT, ST_A_RET, ST_S_RD0, ST_S_LT0, ST_S_CHK, ST_S_RD,
		ST_S_LT, ST_S_NXT, ST_X, ST_XW, ST_DONE
	} state_t;

	state_t state_q, ret_q;
	upc_t pc_q;
	logic [8:0] kc_q;
	logic [IW-1:0] i_q, ia_q, ib_q, last_q;
	logic first_q, vhi_q, before_q, past_q;
	logic m_valid_q;
	logic [1:0] flags_q;

	uop_t u;
	logic [31:0] kc32, n32;
	logic out_free;

	assign u = ucode(pc_q);
	assign kc32 = 32'(kc_q);
	assign n32 = (kc32 < 32'd2) ? 32'd2 :
		(kc32 > 32'(MAX_KNOTS)) ? 32'(MAX_KNOTS) : kc32;
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		cmd = '0;
		cmd.uop = u;
		cmd.v_hi = vhi_q;
		ram_addr = i_q;
		case (state_q)
			ST_IDLE: begin
				cmd.cap = s_tvalid && operation;
				cmd.ram_we = s_tvalid && !operation && (32'(knot_index) < 32'(MAX_KNOTS));
			end
			ST_L_RD0, ST_R_RD, ST_S_RD0: cmd.ram_rd = 1'b1;
			ST_L_RD, ST_S_RD: begin
				cmd.ram_rd = 1'b1;
				ram_addr = i_q + IW'(1);
			end
			ST_L_D0: cmd.d_row = 1'b1;
			ST_L_EV: cmd.d_dd = !sts.dd_neg && (i_q != last_q);
			ST_R_LT, ST_S_LT0, ST_S_LT: cmd.row_lt = 1'b1;
			ST_A_RET: cmd.qab_clr = !first_q;
			ST_X: begin
				cmd.mul_go = (u.op == UOP_MUL);
				cmd.alu_go = (u.op != UOP_MUL);
			end
			ST_DONE: cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			pc_q <= '0;
			kc_q <= 9'd2;
			i_q <= '0;
			ia_q <= '0;
			ib_q <= '0;
			last_q <= '0;
			first_q <= 1'b0;
			vhi_q <= 1'b0;
			before_q <= 1'b0;
			past_q <= 1'b0;
			m_valid_q <= 1'b0;
			flags_q <= '0;
		end else begin
			if (cfg_wr_en)
				kc_q <= cfg_wr_data;
			if (m_valid_q && m_tready && state_q != ST_DONE)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && operation) begin
						before_q <= 1'b0;
						past_q <= 1'b0;
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (sts.lim_eq) begin
						pc_q <= PC_ZERO;
						ret_q <= ST_DONE;
						state_q <= ST_X;
					end else begin
						last_q <= IW'(n32 - 32'd2);
						i_q <= '0;
						vhi_q <= 1'b0;
						first_q <= 1'b1;
						state_q <= ST_L_RD0;
					end
				end
				ST_L_RD0: state_q <= ST_L_D0;
				ST_L_D0: state_q <= ST_L_RD;
				ST_L_RD: state_q <= ST_L_EV;
				ST_L_EV: begin
					if (sts.dd_neg) begin
						state_q <= ST_L_FIN;
					end else if (i_q != last_q) begin
						i_q <= i_q + IW'(1);
						state_q <= ST_L_RD;
					end else begin
						if (sts.dd_pos)
							past_q <= 1'b1;
						state_q <= ST_L_FIN;
					end
				end
				ST_L_FIN: begin
					if (sts.d_neg)
						before_q <= 1'b1;
					state_q <= ST_R_RD;
				end
				ST_R_RD: state_q <= ST_R_LT;
				ST_R_LT: begin
					pc_q <= first_q ? PC_PA : PC_PB;
					ret_q <= ST_A_RET;
					state_q <= ST_X;
				end
				ST_A_RET: begin
					if (first_q) begin
						ia_q <= i_q;
						first_q <= 1'b0;
						vhi_q <= 1'b1;
						state_q <= ST_L_RD0;
					end else begin
						ib_q <= i_q;
						i_q <= ia_q;
						state_q <= ST_S_RD0;
					end
				end
				ST_S_RD0: state_q <= ST_S_LT0;
				ST_S_LT0: state_q <= ST_S_CHK;
				ST_S_CHK: begin
					if (i_q == ib_q) begin
						pc_q <= sts.swap ? PC_REV : PC_FWD;
						ret_q <= ST_DONE;
						state_q <= ST_X;
					end else begin
						state_q <= ST_S_RD;
					end
				end
				ST_S_RD: state_q <= ST_S_LT;
				ST_S_LT: begin
					pc_q <= PC_IV;
					ret_q <= ST_S_NXT;
					state_q <= ST_X;
				end
				ST_S_NXT: begin
					i_q <= i_q + IW'(1);
					state_q <= ST_S_CHK;
				end
				ST_X: begin
					if (u.op == UOP_MUL)
						state_q <= ST_XW;
					else if (u.last)
						state_q <= ret_q;
					else
						pc_q <= pc_q + 6'd1;
				end
				ST_XW: begin
					if (sts.mul_done) begin
						if (u.last) begin
							state_q <= ret_q;
						end else begin
							pc_q <= pc_q + 6'd1;
							state_q <= ST_X;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						flags_q <= {past_q, before_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign flags = flags_q;

endmodule

// File: rtl/cubic_spline_definite_integral.sv
// cubic spline definite integral
// input stream s_*: s_tuser selects the word kind. a load word (s_tuser = 0)
// writes one knot row at knot_index and gives no output.
// a query word (s_tuser = 1) gives one output word on m_*: the saturated
// integral between the two limits and the flags below_first_knot and
// beyond_last_knot.
// cfg_wr_en / cfg_wr_data set the number of knots in use; write it only while
// the block is idle. knot rows must be loaded before a query reads them.
// one query runs on one shared 48-bit multiplier and one knot memory port.
// the two interval searches walk the knot rows in turn; each of the ib - ia
// whole intervals between the limits costs five products and four sums.
// equal limits skip the searches and give zero.
// s_tready is high only between queries. the result sits in an output register
// while m_tready is low; the next word is still taken and a following query
// waits at its end until that register is free.
// reset clears the control state and sets the knot count to 2; the knot rows
// hold nothing defined until loaded.
module cubic_spline_definite_integral #(
	parameter int MAX_KNOTS = csdi_pkg::DEF_MAX_KNOTS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// knot_index, knot_abscissa, knot_ordinate, coef_linear, coef_quadratic,
	// coef_cubic, lower_limit, upper_limit
	input  logic [231:0] s_tdata,
	// operation
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// integral
	output logic [47:0]  m_tdata,
	// below_first_knot, beyond_last_knot
	output logic [1:0]   m_tuser,
	input  logic         cfg_wr_en,
	input  logic [8:0]   cfg_wr_data
);
	import csdi_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [$clog2(MAX_KNOTS)-1:0] ram_addr;
	logic signed [QW-1:0] integral;

	csdi_ctrl #(.MAX_KNOTS(MAX_KNOTS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.operation(s_tuser[0]),
		.knot_index(s_tdata[7:0]),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.flags(m_tuser),
		.sts(sts),
		.cmd(cmd),
		.ram_addr(ram_addr)
	);

	csdi_dp #(.MAX_KNOTS(MAX_KNOTS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.ram_addr(ram_addr),
		.knot_index(s_tdata[7:0]),
		.knot_abscissa(s_tdata[39:8]),
		.knot_ordinate(s_tdata[71:40]),
		.coef_linear(s_tdata[103:72]),
		.coef_quadratic(s_tdata[135:104]),
		.coef_cubic(s_tdata[167:136]),
		.lower_limit(s_tdata[199:168]),
		.upper_limit(s_tdata[231:200]),
		.sts(sts),
		.integral(integral)
	);

	assign m_tdata = integral;

endmodule
